/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the header checker.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define HHC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HHC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HHC_ASSERT(lbl, clk, rst, prop, msg)
`define HHC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/hhc_pkg.sv */
// Types and constants of the HTTP header end and limit checker.
// No dependencies; used by every module of the block.
`default_nettype none

package hhc_pkg;

   localparam int COUNT_W = 26;
   localparam int LINE_W  = 17;
   localparam int FCNT_W  = 11;

   localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
   localparam logic [LINE_W-1:0]  LINE_MAX   = {LINE_W{1'b1}};
   localparam logic [FCNT_W-1:0]  FIELDS_MAX = {FCNT_W{1'b1}};

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam logic [2:0] ST_NEED_MORE  = 3'd0;
   localparam logic [2:0] ST_VALID      = 3'd1;
   localparam logic [2:0] ST_LINE_LONG  = 3'd2;
   localparam logic [2:0] ST_FIELD_LONG = 3'd3;
   localparam logic [2:0] ST_TOO_MANY   = 3'd4;
   localparam logic [2:0] ST_TOTAL      = 3'd5;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_LINE_LONG  = 2'd1;
   localparam logic [1:0] ERR_FIELD_LONG = 2'd2;

   localparam logic [1:0] MATCH_NONE = 2'd0;
   localparam logic [1:0] MATCH_CR   = 2'd1;
   localparam logic [1:0] MATCH_CRLF = 2'd2;
   localparam logic [1:0] MATCH_CRLFCR = 2'd3;

   localparam logic [1:0] REG_MAX_LINE   = 2'd0;
   localparam logic [1:0] REG_MAX_FIELD  = 2'd1;
   localparam logic [1:0] REG_MAX_COUNT  = 2'd2;
   localparam logic [1:0] REG_TOTAL      = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_flag;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [COUNT_W-1:0] header_length;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        max_line_length;
      logic [15:0]        max_field_length;
      logic [9:0]         max_field_count;
      logic [COUNT_W-1:0] total_byte_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         match_progress;
      logic [COUNT_W-1:0] byte_count;
      logic [LINE_W-1:0]  line_length;
      logic               on_request_line;
      logic [FCNT_W-1:0]  field_count;
      logic [1:0]         first_error;
      logic               finished;
   } state_type;

   localparam state_type STATE_CLEAR = '{
      match_progress:  MATCH_NONE,
      byte_count:      '0,
      line_length:     '0,
      on_request_line: 1'b1,
      field_count:     '0,
      first_error:     ERR_NONE,
      finished:        1'b0
   };

endpackage

`default_nettype wire

/* rtl/hhc_cfg.sv */
// Configuration registers of the header checker, written over the csr channel.
// Depends on hhc_pkg.
`default_nettype none

module hhc_cfg (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [1:0]      csr_index,
   input  wire logic [25:0]     csr_data,
   output hhc_pkg::cfg_type     cfg
);
   import hhc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_MAX_LINE:  cfg_in.max_line_length  = csr_data[15:0];
            REG_MAX_FIELD: cfg_in.max_field_length = csr_data[15:0];
            REG_MAX_COUNT: cfg_in.max_field_count  = csr_data[9:0];
            REG_TOTAL:     cfg_in.total_byte_limit = csr_data[COUNT_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_line_length  <= 16'd8190;
         cfg_ff.max_field_length <= 16'd8190;
         cfg_ff.max_field_count  <= 10'd100;
         cfg_ff.total_byte_limit <= 26'd827194;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/hhc_step.sv */
// Per-byte update of the header scan: terminator match, counters and limit checks.
// Depends on hhc_pkg; purely combinational.
`default_nettype none

module hhc_step (
   input  wire hhc_pkg::state_type   cur,
   input  wire hhc_pkg::req_type     req,
   input  wire hhc_pkg::cfg_type     cfg,
   output hhc_pkg::state_type        nxt,
   output hhc_pkg::rsp_type          rsp
);
   import hhc_pkg::*;

   always_comb begin
      state_type          s;
      logic [COUNT_W-1:0] bc;
      logic [LINE_W-1:0]  ll;

      s = req.start_flag ? STATE_CLEAR : cur;
      nxt = s;
      rsp.status = ST_NEED_MORE;
      rsp.header_length = '0;
      bc = (s.byte_count != COUNT_MAX) ? s.byte_count + 1'b1 : s.byte_count;
      ll = (s.line_length != LINE_MAX) ? s.line_length + 1'b1 : s.line_length;

      if (!s.finished) begin
         nxt.byte_count = bc;
         nxt.line_length = ll;
         if (req.data_byte == CHAR_CR) begin
            nxt.match_progress = (s.match_progress == MATCH_CRLF) ? MATCH_CRLFCR : MATCH_CR;
         end else if (req.data_byte == CHAR_LF && s.match_progress == MATCH_CR) begin
            if (s.on_request_line) begin
               if (ll > {1'b0, cfg.max_line_length} && s.first_error == ERR_NONE) begin
                  nxt.first_error = ERR_LINE_LONG;
               end
               nxt.on_request_line = 1'b0;
            end else begin
               if (ll > {1'b0, cfg.max_field_length} && s.first_error == ERR_NONE) begin
                  nxt.first_error = ERR_FIELD_LONG;
               end
               if (s.field_count != FIELDS_MAX) begin
                  nxt.field_count = s.field_count + 1'b1;
               end
            end
            nxt.line_length = '0;
            nxt.match_progress = MATCH_CRLF;
         end else if (req.data_byte == CHAR_LF && s.match_progress == MATCH_CRLFCR) begin
            nxt.match_progress = MATCH_NONE;
            nxt.line_length = '0;
            nxt.finished = 1'b1;
            if (s.first_error == ERR_LINE_LONG) begin
               rsp.status = ST_LINE_LONG;
            end else if (s.first_error == ERR_FIELD_LONG) begin
               rsp.status = ST_FIELD_LONG;
            end else if (s.field_count > {1'b0, cfg.max_field_count}) begin
               rsp.status = ST_TOO_MANY;
            end else begin
               rsp.status = ST_VALID;
            end
            rsp.header_length = bc - COUNT_W'(2);
         end else begin
            nxt.match_progress = MATCH_NONE;
         end

         if (!nxt.finished && bc >= cfg.total_byte_limit) begin
            nxt.finished = 1'b1;
            rsp.status = ST_TOTAL;
            rsp.header_length = bc;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/http_header_end_and_limit_checker.sv */
// Top level of the HTTP header end and limit checker: scan state and result register.
// Depends on hhc_pkg, hhc_cfg, hhc_step and assert_macros.svh.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | data_byte, start_flag
//   rsp     | out       | rsp_valid/rsp_stall | status, header_length
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// Each byte with req_stall low is taken and its status appears in the result register
// on the next cycle; one state update sustains one byte per cycle unless stalled.
// Synchronous reset clears the scan state and the result valid flag and loads the
// default limits. The input stalls only while a held result is itself stalled.
`default_nettype none

`include "assert_macros.svh"

module http_header_end_and_limit_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire hhc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output hhc_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [25:0]      csr_data
);
   import hhc_pkg::*;

   cfg_type   cfg;
   state_type state_ff, state_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff;
   logic      req_take;

   hhc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hhc_step u_step (
      .cur (state_ff),
      .req (req_data),
      .cfg (cfg),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= rsp_in;
      end
   end

   `HHC_ASSERT(a_rsp_from_transfer, clock, reset,
      $rose(rsp_valid_ff) |-> $past(req_take), "result appeared without an input transfer")
   `HHC_ASSERT(a_final_means_finished, clock, reset,
      rsp_valid_ff && rsp_ff.status != ST_NEED_MORE |-> state_ff.finished,
      "final status held while scan is not finished")
   `HHC_ASSERT(a_ignored_after_final, clock, reset,
      req_take && state_ff.finished && !req_data.start_flag |=> rsp_ff.status == ST_NEED_MORE,
      "byte after final status produced a nonzero status")
   `HHC_ASSERT(a_state_stable_idle, clock, reset,
      !req_take |=> $stable(state_ff), "scan state changed without an input transfer")

endmodule

`default_nettype wire
